// ----- sv/keycode_line_assembler_macros.svh -----
// Assertion macros shared by the line assembler.
// Each macro clocks on clk. The first one is also gated off while rst_n is low.
`ifndef KEYCODE_LINE_ASSEMBLER_MACROS_SVH
`define KEYCODE_LINE_ASSEMBLER_MACROS_SVH

// Concurrent check that is switched off while reset is held.
`define KLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also applies during reset.
`define KLA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/kla_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kla_pkg
// Types, codes and the key decoding shared by the line assembler modules.
// ----------------------------------------------------------------------------
package kla_pkg;

    localparam logic [4:0] EV_KEY_TYPE      = 5'd1;
    localparam logic [1:0] PRESS_VALUE      = 2'd1;
    localparam logic [9:0] FIRST_DIGIT_CODE = 10'd2;
    localparam logic [9:0] LAST_DIGIT_CODE  = 10'd11;
    localparam logic [9:0] SPACE_CODE       = 10'd57;
    localparam logic [9:0] TERM_RESET       = 10'd28;
    localparam logic [7:0] CHAR_ZERO        = 8'h30;
    localparam logic [7:0] CHAR_SPACE       = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;

    // Register word index on the configuration port.
    localparam logic REG_TERMINATOR = 1'b0;

    typedef enum logic
    {
        ST_IDLE,
        ST_SEND
    } kla_state_t;

    // Control handed from the sequencer to the row of character cells.
    typedef struct packed
    {
        logic       append;
        logic       shift;
        logic [7:0] ch;
    } kla_store_ctrl_t;

    // ASCII character of a digit or space key; the result only matters for those keys.
    function automatic logic [7:0] key_char(input logic [9:0] code);
        logic [7:0] ch;
        if (code == SPACE_CODE)
        begin
            ch = CHAR_SPACE;
        end
        else if (code == LAST_DIGIT_CODE)
        begin
            ch = CHAR_ZERO;
        end
        else
        begin
            ch = CHAR_ZERO + code[7:0] - 8'd1;
        end
        return ch;
    endfunction

endpackage

// ----- sv/keycode_line_assembler.sv -----
`timescale 1ns / 1ps
// Acceptance: a character or ignored event transaction is taken whenever the sequencer is idle; a
// clean terminator moves the sequencer to its send state, and each result is then registered.
// Throughput: a terminator holds s_tready low until its newline is registered, one result per cycle
// while m_tready is high, set by the cell row moving one character to cell 0 per cycle.
// Reset: rst_n clears the fill count, spoiled flag, sequencer and output valid at once and
// restores the terminator key to 28; the character cells are not reset.
// ----------------------------------------------------------------------------
// keycode_line_assembler
// Collects digit and space key presses into a line and replays the line,
// followed by a newline, when the terminator key is pressed.
// ----------------------------------------------------------------------------
module keycode_line_assembler
#(
    parameter int BUFFER_BYTES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Input events.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] key_code, [15:10] zero
    input  logic [7:0]  s_tuser,   // [4:0] event_type, [6:5] key_value, [7] zero

    // Output characters.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] character
    output logic        m_tlast,   // set on the closing newline

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import kla_pkg::*;

    `include "keycode_line_assembler_macros.svh"

    // The line holds one character fewer than the buffer size.
    localparam int DEPTH = BUFFER_BYTES - 1;
    localparam int CW    = $clog2(DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration register. Byte lanes within the word are ignored, so
    // the word index is paddr[2].
    // ------------------------------------------------------------------
    logic [9:0] term_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TERMINATOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= TERM_RESET;
        end
        else if (cfg_wr)
        begin
            term_reg <= pwdata[9:0];
        end
    end

    assign prdata = (paddr[2] == REG_TERMINATOR) ? {22'd0, term_reg} : 32'd0;

    // ------------------------------------------------------------------
    // Event decoding.
    // ------------------------------------------------------------------
    logic [9:0] code;
    logic       accept;
    logic       press;
    logic       is_term;
    logic       is_char;

    assign code    = s_tdata[9:0];
    assign accept  = s_tvalid && s_tready;
    assign press   = (s_tuser[4:0] == EV_KEY_TYPE) && (s_tuser[6:5] == PRESS_VALUE);
    assign is_term = (code == term_reg);
    assign is_char = (code inside {[FIRST_DIGIT_CODE:LAST_DIGIT_CODE]}) || (code == SPACE_CODE);

    // ------------------------------------------------------------------
    // Sequencer state.
    // ------------------------------------------------------------------
    kla_state_t      state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic            spoiled_reg, spoiled_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_char_reg, out_char_next;
    logic            out_last_reg, out_last_next;
    logic            slot_free;
    logic [7:0]      head_char;
    kla_store_ctrl_t store_ctrl;

    // The output register can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rem_reg       <= '0;
            spoiled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            spoiled_reg   <= spoiled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        rem_next         = rem_reg;
        spoiled_next     = spoiled_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;
        store_ctrl.append = 1'b0;
        store_ctrl.shift  = 1'b0;
        store_ctrl.ch     = key_char(code);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && press)
                begin
                    if (is_term)
                    begin
                        // The terminator wins over every other meaning of the key.
                        // On a clean line the fill count is handed over to the replay counter.
                        if (!spoiled_reg)
                        begin
                            rem_next   = fill_reg;
                            state_next = ST_SEND;
                        end
                        fill_next    = '0;
                        spoiled_next = 1'b0;
                    end
                    else if (spoiled_reg)
                    begin
                        // Keys on a spoiled line are dropped.
                    end
                    else if (is_char)
                    begin
                        if (fill_reg < CW'(DEPTH))
                        begin
                            store_ctrl.append = 1'b1;
                            fill_next         = fill_reg + CW'(1);
                        end
                        else
                        begin
                            spoiled_next = 1'b1;
                        end
                    end
                    else
                    begin
                        spoiled_next = 1'b1;
                    end
                end
            end

            ST_SEND:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (rem_reg != '0)
                    begin
                        // Cell 0 holds the oldest character still to send.
                        out_char_next    = head_char;
                        out_last_next    = 1'b0;
                        store_ctrl.shift = 1'b1;
                        rem_next         = rem_reg - CW'(1);
                    end
                    else
                    begin
                        out_char_next = CHAR_NEWLINE;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    kla_line_store
    #(
        .DEPTH (DEPTH)
    )
    u_store
    (
        .clk       (clk),
        .ctrl      (store_ctrl),
        .fill      (fill_reg),
        .head_char (head_char)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Checks. The reset check looks past the edge that samples reset, since the registers only
    // take their reset values once reset has been seen.
    // ------------------------------------------------------------------
    `KLA_ASSERT(a_clean_term_starts_replay,
        (accept && press && is_term && !spoiled_reg) |=> (state_reg == ST_SEND),
        "clean terminator did not start a replay")
    `KLA_ASSERT(a_newline_closes_replay,
        (state_reg == ST_SEND && slot_free && rem_reg == '0)
            |=> (m_tvalid && m_tlast && m_tdata == CHAR_NEWLINE && state_reg == ST_IDLE),
        "replay did not close with a newline")
    `KLA_ASSERT(a_spoiled_holds,
        (spoiled_reg && !(accept && press && is_term)) |=> spoiled_reg,
        "spoiled flag cleared before the line ended")
    `KLA_ASSERT(a_fill_bound,
        (state_reg == ST_SEND) |-> (fill_reg == '0 && rem_reg <= CW'(DEPTH)),
        "fill count or replay count out of range during replay")
    `KLA_ASSERT_ALWAYS(a_reset_quiet,
        !rst_n |=> (!m_tvalid && s_tready),
        "output valid or input stall during reset")

endmodule

// ----- sv/kla_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kla_cell
// One character cell: loads a new character or takes its neighbour's.
// ----------------------------------------------------------------------------
module kla_cell
(
    input  logic       clk,
    input  logic       load,
    input  logic       shift,
    input  logic [7:0] load_char,
    input  logic [7:0] neigh_char,
    output logic [7:0] cell_char
);

    logic [7:0] char_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= load_char;
        end
        else if (shift)
        begin
            char_reg <= neigh_char;
        end
    end

    assign cell_char = char_reg;

endmodule

// ----- sv/kla_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kla_line_store
// Row of character cells. A character is written into the cell whose index
// equals the fill count; replay moves every cell one place towards cell 0.
// ----------------------------------------------------------------------------
module kla_line_store
#(
    parameter int DEPTH = 63
)
(
    input  logic                         clk,
    input  kla_pkg::kla_store_ctrl_t     ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]   fill,
    output logic [7:0]                   head_char
);

    import kla_pkg::*;

    localparam int IW = $clog2(DEPTH + 1);

    logic [7:0] cell_char [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [7:0] neigh;
        logic       load;

        assign load = ctrl.append && (fill == IW'(i));

        if (i == DEPTH - 1)
        begin : g_tail
            assign neigh = '0;
        end
        else
        begin : g_mid
            assign neigh = cell_char[i+1];
        end

        kla_cell u_cell
        (
            .clk        (clk),
            .load       (load),
            .shift      (ctrl.shift),
            .load_char  (ctrl.ch),
            .neigh_char (neigh),
            .cell_char  (cell_char[i])
        );
    end

    assign head_char = cell_char[0];

endmodule

// ----- dv/keycode_line_assembler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keycode_line_assembler_tb
// Self-checking bench for the key code line assembler. Key events go in on
// the slave stream and the terminator key is set over the register port. A
// small scoreboard tracks the line store and works out which characters each
// event should release. Every character transaction on the master stream is
// then compared with the oldest outstanding prediction. Four idling phases,
// one with no idling and the rest putting back-pressure on the sender, the
// receiver or both, each run with their own terminator key.
// ----------------------------------------------------------------------------
module keycode_line_assembler_tb;

    import kla_pkg::*;

    localparam int BUFFER_BYTES  = 64;
    localparam int LINE_CAP      = BUFFER_BYTES - 1;
    localparam int PHASE_ITEMS   = 80;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = BUFFER_BYTES + 8;
    localparam int MAX_PRINTED   = 40;

    // Key values other than a press; the block must ignore all of them.
    localparam logic [1:0] RELEASE_VALUE = 2'd0;
    localparam logic [1:0] REPEAT_VALUE  = 2'd2;
    localparam logic [1:0] SPARE_VALUE   = 2'd3;

    // Byte address of the terminator register: word index times four.
    localparam logic [2:0] TERM_ADDR = 3'(REG_TERMINATOR) << 2;

    // One character the block is expected to send.
    typedef struct packed
    {
        logic [7:0] character;
        logic       last;
    } line_char_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a copy of the line store and the spoiled flag, together with
    // the queue of characters that have been predicted but not yet seen.
    // ------------------------------------------------------------------------
    class line_scoreboard;
        logic [7:0]  line_chars [LINE_CAP];
        int unsigned fill;
        bit          spoiled;
        logic [9:0]  terminator;
        line_char_t  pending_chars [$];

        int unsigned n_errors;
        int unsigned n_presses;
        int unsigned n_checked;
        int unsigned n_clean_lines;
        int unsigned n_spoiled_lines;
        int unsigned n_full_lines;

        function new();
            fill       = 0;
            spoiled    = 1'b0;
            terminator = TERM_RESET;
        endfunction

        task report(input string msg);
            n_errors++;
            if (n_errors <= MAX_PRINTED)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        function void set_terminator(input logic [9:0] code);
            terminator = code;
        endfunction

        function int unsigned pending();
            return pending_chars.size();
        endfunction

        // Appends a character, or spoils the line when there is no room left.
        function void store_char(input logic [7:0] ch);
            if (fill < LINE_CAP)
            begin
                line_chars[fill] = ch;
                fill++;
            end
            else
            begin
                spoiled = 1'b1;
                n_full_lines++;
            end
        endfunction

        // Called for every transaction accepted on the slave stream.
        function void note_event(input logic [4:0] ev_type, input logic [1:0] value,
                                 input logic [9:0] code);
            line_char_t item;
            if (ev_type != EV_KEY_TYPE || value != PRESS_VALUE)
            begin
                return;
            end
            n_presses++;
            // The terminator is tested first, so a digit or space key used as
            // terminator ends the line rather than being stored.
            if (code == terminator)
            begin
                if (!spoiled)
                begin
                    for (int i = 0; i < fill; i++)
                    begin
                        item.character = line_chars[i];
                        item.last      = 1'b0;
                        pending_chars.push_back(item);
                    end
                    item.character = CHAR_NEWLINE;
                    item.last      = 1'b1;
                    pending_chars.push_back(item);
                    n_clean_lines++;
                end
                else
                begin
                    n_spoiled_lines++;
                end
                fill    = 0;
                spoiled = 1'b0;
            end
            else if (spoiled)
            begin
                // Everything up to the terminator is dropped.
            end
            else if (code >= FIRST_DIGIT_CODE && code <= LAST_DIGIT_CODE)
            begin
                // Codes 2 to 10 are the digits one to nine, code 11 is zero.
                if (code == LAST_DIGIT_CODE)
                begin
                    store_char(CHAR_ZERO);
                end
                else
                begin
                    store_char(CHAR_ZERO + 8'(code - FIRST_DIGIT_CODE) + 8'd1);
                end
            end
            else if (code == SPACE_CODE)
            begin
                store_char(CHAR_SPACE);
            end
            else
            begin
                spoiled = 1'b1;
            end
        endfunction

        // Called for every transaction accepted on the master stream.
        task check_result(input logic [7:0] character, input logic last);
            line_char_t want;
            if (pending_chars.size() == 0)
            begin
                report($sformatf("character %02h last %0b arrived with nothing expected",
                                 character, last));
                return;
            end
            want = pending_chars.pop_front();
            n_checked++;
            if (character !== want.character)
            begin
                report($sformatf("character %02h, expected %02h", character, want.character));
            end
            if (last !== want.last)
            begin
                report($sformatf("last %0b on character %02h, expected %0b",
                                 last, want.character, want.last));
            end
        endtask

        task flush_leftover();
            line_char_t want;
            while (pending_chars.size() != 0)
            begin
                want = pending_chars.pop_front();
                report($sformatf("character %02h last %0b never arrived",
                                 want.character, want.last));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the block starts at a known value.
    // ------------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [9:0] key_code, [15:10] zero
    logic [7:0]  s_tuser  = '0;   // [4:0] event_type, [6:5] key_value, [7] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] character
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Percentages of cycles in which the sender holds back or the receiver
    // stalls. They change from one phase to the next.
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;

    line_scoreboard sb = new();

    keycode_line_assembler
    #(
        .BUFFER_BYTES(BUFFER_BYTES)
    )
    u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The receiver decides afresh at every edge whether to accept.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99, 0) >= snk_stall_pct);
    end

    // Output values read here are those from before the edge, so the check
    // sees exactly the transaction that the edge completes.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tlast);
        end
    end

    // Watchdog: ends the run if no transaction of any kind completes for a
    // long stretch of cycles.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)
                || !rst_n)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("[keycode_line_assembler] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Register port. Each access first waits for a clock edge, so psel is never lowered
    // and raised again within the same time step.
    // ------------------------------------------------------------------------
    task automatic reg_write(input logic [9:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TERM_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_terminator(value);
    endtask

    task automatic reg_readback();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TERM_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== 32'(sb.terminator))
        begin
            sb.report($sformatf("terminator reads %08h, expected %08h",
                                prdata, 32'(sb.terminator)));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Event sender. Here tvalid is lowered only when an idle gap is taken, so a
    // run of back-to-back transactions never sees it dropped and raised in
    // the same step.
    // ------------------------------------------------------------------------
    task automatic send_event(input logic [4:0] ev_type, input logic [1:0] value,
                              input logic [9:0] code);
        while ($urandom_range(99, 0) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, code};
        s_tuser  <= {1'b0, value, ev_type};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_event(ev_type, value, code);
    endtask

    task automatic press(input logic [9:0] code);
        send_event(EV_KEY_TYPE, PRESS_VALUE, code);
    endtask

    // An event of any type and value that is not a key press.
    task automatic send_noise();
        logic [4:0] ev_type;
        logic [1:0] value;
        ev_type = 5'($urandom_range(31, 0));
        value   = 2'($urandom_range(3, 0));
        if (ev_type == EV_KEY_TYPE && value == PRESS_VALUE)
        begin
            value = $urandom_range(1, 0) ? RELEASE_VALUE : SPARE_VALUE;
        end
        send_event(ev_type, value, 10'($urandom_range(1023, 0)));
    endtask

    function automatic logic [9:0] text_code();
        if ($urandom_range(99, 0) < 85)
        begin
            return 10'($urandom_range(LAST_DIGIT_CODE, FIRST_DIGIT_CODE));
        end
        return SPACE_CODE;
    endfunction

    // A pressed key that is neither text nor the terminator, so it spoils.
    function automatic logic [9:0] spoiling_code();
        logic [9:0] code;
        do
        begin
            code = 10'($urandom_range(1023, 0));
        end
        while ((code >= FIRST_DIGIT_CODE && code <= LAST_DIGIT_CODE)
               || code == SPACE_CODE || code == sb.terminator);
        return code;
    endfunction

    // One well-formed line: text keys with the odd ignored event mixed in,
    // sometimes a spoiling key, then the terminator. A few lines are long
    // enough to fill the store exactly or to run past its end.
    task automatic send_line();
        int unsigned len;
        int unsigned spoil_at;
        if ($urandom_range(99, 0) < 8)
        begin
            len = $urandom_range(LINE_CAP + 3, LINE_CAP - 3);
        end
        else
        begin
            len = $urandom_range(10, 0);
        end
        spoil_at = ($urandom_range(99, 0) < 6) ? $urandom_range(len, 0) : len + 1;
        for (int i = 0; i <= len; i++)
        begin
            if ($urandom_range(99, 0) < 8)
            begin
                send_noise();
            end
            if (i == spoil_at)
            begin
                press(spoiling_code());
            end
            if (i < len)
            begin
                press(text_code());
            end
        end
        press(sb.terminator);
    endtask

    // Brings the block to rest: no event offered, every predicted character
    // delivered, and time for a terminator on a spoiled line to finish.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int unsigned phase_src [4];
        int unsigned phase_snk [4];
        logic [9:0]  phase_term [4];
        int unsigned start_presses;

        // No idling, sender idle, receiver stalling, then both lightly. The
        // terminator takes code zero, code 767, the first digit code and the space code.
        phase_src  = '{0, 86, 0, 8};
        phase_snk  = '{0, 0, 86, 8};
        phase_term = '{10'd0, 10'd767, FIRST_DIGIT_CODE, SPACE_CODE};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The register should come out of reset holding the enter key.
        reg_readback();
        reg_write(TERM_RESET);

        // Directed part. An empty line gives a lone newline.
        press(sb.terminator);
        // Every digit and the space key, then the line is replayed.
        for (int code = FIRST_DIGIT_CODE; code <= LAST_DIGIT_CODE; code++)
        begin
            press(10'(code));
        end
        press(SPACE_CODE);
        press(sb.terminator);
        // Releases, autorepeats, the unused key value and foreign event
        // types all leave the line alone.
        send_event(EV_KEY_TYPE, RELEASE_VALUE, FIRST_DIGIT_CODE);
        send_event(EV_KEY_TYPE, REPEAT_VALUE, 10'd3);
        send_event(EV_KEY_TYPE, SPARE_VALUE, 10'd4);
        send_event(5'd0, PRESS_VALUE, 10'd5);
        send_event(5'd31, PRESS_VALUE, 10'd6);
        // A stored digit, then an unknown key: the line is spoiled, the next
        // digit is dropped and the terminator sends nothing at all.
        press(10'd7);
        press(10'd0);
        press(10'd8);
        press(sb.terminator);
        // The highest key code spoils a line that is still empty.
        press(10'd1023);
        press(sb.terminator);
        // A clean line straight after a spoiled one.
        press(10'd9);
        press(sb.terminator);
        drain();

        // Random part, one block per idling phase.
        for (int p = 0; p < 4; p++)
        begin
            reg_write(phase_term[p]);
            reg_readback();
            src_idle_pct  = phase_src[p];
            snk_stall_pct = phase_snk[p];
            start_presses = sb.n_presses;
            while (sb.n_presses - start_presses < PHASE_ITEMS)
            begin
                send_line();
            end
            drain();
        end

        sb.flush_leftover();
        $display("run covered %0d key presses in four idling phases, %0d characters checked",
                 sb.n_presses, sb.n_checked);
        $display("lines: %0d clean, %0d spoiled, %0d spoiled by a full store",
                 sb.n_clean_lines, sb.n_spoiled_lines, sb.n_full_lines);
        if (sb.n_errors == 0)
        begin
            $display("[keycode_line_assembler] OK");
        end
        else
        begin
            $display("%0d mismatches", sb.n_errors);
            $display("[keycode_line_assembler] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/kla_pkg.sv
sv/kla_cell.sv
sv/kla_line_store.sv
sv/keycode_line_assembler.sv
dv/keycode_line_assembler_tb.sv
